// File: sv/arsf_pkg.sv
`default_nettype none
package arsf_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int COORD_W = 18;
  localparam int THR_W = 16;
  localparam int RAD_W = 40;
  localparam int OUT_W = 48;
  localparam int DIV_W = 64;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: sv/arsf_point_ram.sv
`default_nettype none
module arsf_point_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 36
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/arsf_divider.sv
`default_nettype none
module arsf_divider (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire arsf_pkg::div_req_t req,
  output arsf_pkg::div_rsp_t      rsp
);

  logic [arsf_pkg::DIV_W-1:0]     rem_r;
  logic [arsf_pkg::DIV_W-1:0]     quo_r;
  logic [arsf_pkg::DIV_W-1:0]     dvs_r;
  logic [arsf_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           run_r;
  logic                           done_r;
  logic [arsf_pkg::DIV_W:0]       shifted;
  logic [arsf_pkg::DIV_W:0]       diff;
  logic                           fits;

  assign shifted = {rem_r, quo_r[arsf_pkg::DIV_W-1]};
  assign diff = shifted - {1'b0, dvs_r};
  assign fits = !diff[arsf_pkg::DIV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= req.dividend;
        dvs_r <= req.divisor;
      end else if (run_r) begin
        rem_r <= fits ? diff[arsf_pkg::DIV_W-1:0] : shifted[arsf_pkg::DIV_W-1:0];
        quo_r <= {quo_r[arsf_pkg::DIV_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == arsf_pkg::DIV_CNT_W'(arsf_pkg::DIV_W - 1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// File: sv/arc_radius_least_squares_fit_unit.sv
`default_nettype none
// An item is accepted when start is high and busy is low. A stored item then holds busy
// high through ST_SQ, ST_MUL and ST_ADD while it is added to the sums; no new item is taken
// before that. A dropped item (store full) raises busy only if it is last. A last item adds
// the fit: ST_FIT, the radius division (skipped when straight), ST_RD, ST_RMUL and ST_RADD
// per stored point, the mean division and ST_OUT for the strobe. The receiver cannot stall.
// Synchronous active-low reset clears the batch and loads the threshold with 17.
module arc_radius_least_squares_fit_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [arsf_pkg::COORD_W-1:0] in_point_x,
  input  wire logic signed [arsf_pkg::COORD_W-1:0] in_point_y,
  input  wire logic                            in_last_point,
  input  wire logic                            cfg_wr_en,
  input  wire logic [arsf_pkg::THR_W-1:0]      cfg_wr_data,
  output logic                                 out_valid,
  output logic signed [arsf_pkg::RAD_W-1:0]    out_radius,
  output logic                                 out_radius_infinite,
  output logic [arsf_pkg::OUT_W-1:0]           out_mean_residual,
  output logic [arsf_pkg::OUT_W-1:0]           out_max_residual,
  output logic                                 out_truncated
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_MUL, ST_ADD, ST_FIT, ST_RAD_WAIT,
    ST_RD, ST_RMUL, ST_RADD, ST_MEAN, ST_MEAN_WAIT, ST_OUT
  } state_t;

  localparam int CW = arsf_pkg::COORD_W;

  state_t state_r;
  logic [arsf_pkg::THR_W-1:0]  thr_r;
  logic [45:0]                 sum_d_r;
  logic signed [63:0]          sum_n_r;
  logic [arsf_pkg::CNT_W-1:0]  count_r;
  logic                        ovf_r;
  logic signed [CW-1:0]        px_r;
  logic signed [CW-1:0]        py_r;
  logic                        last_r;
  logic [34:0]                 xx_r;
  logic [34:0]                 yy_r;
  logic signed [54:0]          prod_r;
  logic                        straight_r;
  logic signed [arsf_pkg::RAD_W-1:0] radius_r;
  logic [arsf_pkg::ADDR_W-1:0] idx_r;
  logic                        rneg_r;
  logic [34:0]                 rxx_r;
  logic [34:0]                 ryy_r;
  logic signed [57:0]          ryr_r;
  logic [63:0]                 acc_r;
  logic [59:0]                 worst_r;
  logic                        div_start_r;
  logic [63:0]                 div_a_r;
  logic [63:0]                 div_b_r;

  arsf_pkg::div_req_t div_req;
  arsf_pkg::div_rsp_t div_rsp;

  logic accept;
  logic ram_we;
  logic ram_re;
  logic [2*CW-1:0] ram_rd;
  logic signed [CW-1:0] ram_x;
  logic signed [CW-1:0] ram_y;

  logic signed [35:0] sq_x;
  logic signed [35:0] sq_y;
  logic [35:0]        norm;
  logic signed [54:0] prod_c;
  logic [46:0]        d_sum;
  logic signed [64:0] n_sum;
  logic signed [35:0] r_sq_x;
  logic signed [35:0] r_sq_y;
  logic signed [57:0] r_yr;
  logic signed [60:0] t_c;
  logic [59:0]        t_abs;
  logic [59:0]        res_c;
  logic [64:0]        acc_sum;
  logic               is_straight;
  logic [63:0]        n_mag;
  logic [63:0]        q;

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);
  assign ram_we = accept && (count_r < arsf_pkg::CNT_W'(arsf_pkg::MAX_POINTS));
  assign ram_re = (state_r == ST_RD);
  assign ram_x = ram_rd[2*CW-1:CW];
  assign ram_y = ram_rd[CW-1:0];

  arsf_point_ram #(
    .DEPTH(arsf_pkg::MAX_POINTS),
    .WIDTH(2 * CW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(count_r[arsf_pkg::ADDR_W-1:0]),
    .wr_data({in_point_x, in_point_y}),
    .rd_en  (ram_re),
    .rd_addr(idx_r),
    .rd_data(ram_rd)
  );

  assign div_req.start = div_start_r;
  assign div_req.dividend = div_a_r;
  assign div_req.divisor = div_b_r;

  arsf_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign sq_x = px_r * px_r;
  assign sq_y = py_r * py_r;
  assign norm = {1'b0, xx_r} + {1'b0, yy_r};
  assign prod_c = py_r * $signed({1'b0, norm});
  assign d_sum = {1'b0, sum_d_r} + {11'b0, yy_r, 1'b0};
  assign n_sum = {sum_n_r[63], sum_n_r} + {{10{prod_r[54]}}, prod_r};

  assign r_sq_x = ram_x * ram_x;
  assign r_sq_y = ram_y * ram_y;
  assign r_yr = ram_y * radius_r;
  assign t_c = $signed({26'b0, ryy_r}) + $signed({26'b0, rxx_r})
             - $signed({{2{ryr_r[57]}}, ryr_r, 1'b0});
  assign t_abs = t_c[60] ? 60'(-t_c) : t_c[59:0];
  always_comb begin
    if (rneg_r) begin
      res_c = {24'b0, ({1'b0, rxx_r} + {1'b0, ryy_r})};
    end else if (straight_r) begin
      res_c = {25'b0, ryy_r};
    end else begin
      res_c = t_abs;
    end
  end
  assign acc_sum = {1'b0, acc_r} + {5'b0, res_c};

  assign is_straight = (sum_d_r == '0) || (sum_d_r < {30'b0, thr_r});
  assign n_mag = sum_n_r[63] ? (64'd0 - 64'(sum_n_r)) : 64'(sum_n_r);
  assign q = div_rsp.quotient;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      thr_r <= arsf_pkg::THR_RESET;
      sum_d_r <= '0;
      sum_n_r <= '0;
      count_r <= '0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      div_start_r <= 1'b0;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            px_r <= in_point_x;
            py_r <= in_point_y;
            last_r <= in_last_point;
            if (ram_we) begin
              state_r <= ST_SQ;
            end else begin
              ovf_r <= 1'b1;
              if (in_last_point) begin
                state_r <= ST_FIT;
              end
            end
          end
        end
        ST_SQ: begin
          xx_r <= sq_x[34:0];
          yy_r <= sq_y[34:0];
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= prod_c;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          sum_d_r <= d_sum[46] ? {46{1'b1}} : d_sum[45:0];
          if (n_sum[64] != n_sum[63]) begin
            sum_n_r <= n_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
          end else begin
            sum_n_r <= n_sum[63:0];
          end
          count_r <= count_r + 1'b1;
          state_r <= last_r ? ST_FIT : ST_IDLE;
        end
        ST_FIT: begin
          straight_r <= is_straight;
          radius_r <= '0;
          acc_r <= '0;
          worst_r <= '0;
          idx_r <= '0;
          if (!is_straight) begin
            div_a_r <= n_mag;
            div_b_r <= {18'b0, sum_d_r};
            div_start_r <= 1'b1;
            state_r <= ST_RAD_WAIT;
          end else if (count_r == '0) begin
            state_r <= ST_MEAN;
          end else begin
            state_r <= ST_RD;
          end
        end
        ST_RAD_WAIT: begin
          if (div_rsp.done) begin
            if (sum_n_r[63]) begin
              if (q > {24'b0, 1'b1, 39'b0}) begin
                radius_r <= {1'b1, 39'b0};
              end else begin
                radius_r <= 40'(-q[39:0]);
              end
            end else if (q > {25'b0, {39{1'b1}}}) begin
              radius_r <= {1'b0, {39{1'b1}}};
            end else begin
              radius_r <= q[39:0];
            end
            state_r <= (count_r == '0) ? ST_MEAN : ST_RD;
          end
        end
        ST_RD: begin
          state_r <= ST_RMUL;
        end
        ST_RMUL: begin
          rneg_r <= ram_x[CW-1];
          rxx_r <= r_sq_x[34:0];
          ryy_r <= r_sq_y[34:0];
          ryr_r <= r_yr;
          state_r <= ST_RADD;
        end
        ST_RADD: begin
          acc_r <= acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
          if (res_c > worst_r) begin
            worst_r <= res_c;
          end
          idx_r <= idx_r + 1'b1;
          if ({1'b0, idx_r} + 1'b1 == count_r) begin
            state_r <= ST_MEAN;
          end else begin
            state_r <= ST_RD;
          end
        end
        ST_MEAN: begin
          div_a_r <= acc_r;
          div_b_r <= {{(64 - arsf_pkg::CNT_W){1'b0}}, count_r};
          if (count_r == '0) begin
            state_r <= ST_OUT;
          end else begin
            div_start_r <= 1'b1;
            state_r <= ST_MEAN_WAIT;
          end
        end
        ST_MEAN_WAIT: begin
          if (div_rsp.done) begin
            out_mean_residual <= (q[63:48] != '0) ? {48{1'b1}} : q[47:0];
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (count_r == '0) begin
            out_mean_residual <= '0;
          end
          out_valid <= 1'b1;
          out_radius <= radius_r;
          out_radius_infinite <= straight_r;
          out_max_residual <= (worst_r[59:48] != '0) ? {48{1'b1}} : worst_r[47:0];
          out_truncated <= ovf_r;
          sum_d_r <= '0;
          sum_n_r <= '0;
          count_r <= '0;
          ovf_r <= 1'b0;
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: dv/arc_radius_least_squares_fit_unit_test.sv
`timescale 1ns / 1ps
module arc_radius_least_squares_fit_unit_test;

  localparam int CW = arsf_pkg::COORD_W;
  localparam int RW = arsf_pkg::RAD_W;
  localparam int OW = arsf_pkg::OUT_W;
  localparam int TW = arsf_pkg::THR_W;
  localparam int MAXP = arsf_pkg::MAX_POINTS;

  typedef struct {
    logic signed [RW-1:0] radius;
    logic                 radius_infinite;
    logic [OW-1:0]        mean_residual;
    logic [OW-1:0]        max_residual;
    logic                 truncated;
  } fit_result_t;

  class fit_scoreboard;
    longint xs[MAXP];
    longint ys[MAXP];
    logic [45:0] sum_d;
    longint sum_n;
    int count;
    bit dropped;
    logic [TW-1:0] threshold;
    fit_result_t pending[$];
    int errors;
    int fits;
    int curved;

    function void clear_batch();
      sum_d = 0;
      sum_n = 0;
      count = 0;
      dropped = 0;
    endfunction

    function void reset_state();
      clear_batch();
      threshold = arsf_pkg::THR_RESET;
      pending.delete();
    endfunction

    function void note_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                             logic last);
      longint x, y, yy, nrm, prod, r, t;
      logic [64:0] dsum;
      logic [64:0] asum;
      logic [63:0] acc, worst, mag, q, mean;
      longint rad;
      bit straight;
      fit_result_t res;
      x = px;
      y = py;
      if (count < MAXP) begin
        xs[count] = x;
        ys[count] = y;
        count++;
        yy = y * y;
        nrm = x * x + yy;
        dsum = {19'd0, sum_d} + 65'(2 * yy);
        sum_d = (dsum > 65'(46'h3FFF_FFFF_FFFF)) ? 46'h3FFF_FFFF_FFFF : dsum[45:0];
        prod = y * nrm;
        if (prod > 0 && sum_n > 64'sh7FFF_FFFF_FFFF_FFFF - prod)
          sum_n = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (prod < 0 && sum_n < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - prod)
          sum_n = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
        else
          sum_n = sum_n + prod;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      straight = (sum_d == 0) || (sum_d < 46'(threshold));
      rad = 0;
      if (!straight) begin
        curved++;
        mag = (sum_n < 0) ? -sum_n : sum_n;
        q = mag / 64'(sum_d);
        if (sum_n < 0)
          rad = (q > 64'd549755813888) ? -64'sd549755813888 : -longint'(q);
        else
          rad = (q > 64'd549755813887) ? 64'sd549755813887 : longint'(q);
      end
      acc = 0;
      worst = 0;
      for (int i = 0; i < count; i++) begin
        if (xs[i] < 0) r = xs[i] * xs[i] + ys[i] * ys[i];
        else if (straight) r = ys[i] * ys[i];
        else begin
          t = ys[i] * ys[i] - 2 * (ys[i] * rad) + xs[i] * xs[i];
          r = (t < 0) ? -t : t;
        end
        asum = {1'b0, acc} + {1'b0, 64'(r)};
        acc = asum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : asum[63:0];
        if (64'(r) > worst) worst = 64'(r);
      end
      mean = (count != 0) ? acc / 64'(count) : 0;
      res.radius = RW'(rad);
      res.radius_infinite = straight;
      res.mean_residual = (mean > 64'hFFFF_FFFF_FFFF) ? '1 : mean[OW-1:0];
      res.max_residual = (worst > 64'hFFFF_FFFF_FFFF) ? '1 : worst[OW-1:0];
      res.truncated = dropped;
      pending = {pending, res};
      clear_batch();
    endfunction

    function void check_fit(fit_result_t got);
      fit_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no fit pending");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      fits++;
      if (got.radius !== exp_r.radius) begin
        $error("radius: expected %0d, actual %0d", exp_r.radius, got.radius);
        errors++;
      end
      if (got.radius_infinite !== exp_r.radius_infinite) begin
        $error("radius_infinite: expected %0d, actual %0d", exp_r.radius_infinite,
               got.radius_infinite);
        errors++;
      end
      if (got.mean_residual !== exp_r.mean_residual) begin
        $error("mean_residual: expected %0d, actual %0d", exp_r.mean_residual,
               got.mean_residual);
        errors++;
      end
      if (got.max_residual !== exp_r.max_residual) begin
        $error("max_residual: expected %0d, actual %0d", exp_r.max_residual,
               got.max_residual);
        errors++;
      end
      if (got.truncated !== exp_r.truncated) begin
        $error("truncated: expected %0d, actual %0d", exp_r.truncated, got.truncated);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [CW-1:0] in_point_x;
  logic signed [CW-1:0] in_point_y;
  logic in_last_point;
  logic cfg_wr_en;
  logic [TW-1:0] cfg_wr_data;
  logic out_valid;
  logic signed [RW-1:0] out_radius;
  logic out_radius_infinite;
  logic [OW-1:0] out_mean_residual;
  logic [OW-1:0] out_max_residual;
  logic out_truncated;

  fit_scoreboard fit_sb;
  int point_total;
  bit quiet_stretch;

  arc_radius_least_squares_fit_unit i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_last_point(in_last_point),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_radius(out_radius),
    .out_radius_infinite(out_radius_infinite),
    .out_mean_residual(out_mean_residual),
    .out_max_residual(out_max_residual),
    .out_truncated(out_truncated)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[arc_radius_least_squares_fit_unit] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    fit_result_t got;
    if (rst_n && out_valid) begin
      got.radius = out_radius;
      got.radius_infinite = out_radius_infinite;
      got.mean_residual = out_mean_residual;
      got.max_residual = out_max_residual;
      got.truncated = out_truncated;
      fit_sb.check_fit(got);
    end
  end

  task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                            logic last);
    if (!quiet_stretch) begin
      while ($urandom_range(99) < 6) begin
        start <= 0;
        @(negedge clk);
      end
    end
    start <= 1;
    in_point_x <= px;
    in_point_y <= py;
    in_last_point <= last;
    do @(posedge clk); while (busy);
    fit_sb.note_point(px, py, last);
    point_total++;
    @(negedge clk);
  endtask

  task automatic drain_fits();
    start <= 0;
    while (fit_sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_threshold(logic [TW-1:0] value);
    drain_fits();
    cfg_wr_en <= 1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 0;
    fit_sb.threshold = value;
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 18'sh1FFFF;
      1: return 18'sh20000;
      2: return CW'($urandom_range(8191)) - 18'sd4096;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_batch(int len);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(), rand_coord(), i == len - 1);
  endtask

  initial begin
    int len;
    fit_sb = new();
    fit_sb.reset_state();
    rst_n = 0;
    start = 0;
    in_point_x = 0;
    in_point_y = 0;
    in_last_point = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    point_total = 0;
    quiet_stretch = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    send_point(18'sh1FFFF, 18'sh1FFFF, 0);
    send_point(18'sh20000, 18'sh20000, 0);
    send_point(18'sh20000, 18'sh1FFFF, 1);
    send_point(0, 0, 1);
    send_point(18'sd4096, 18'sd1, 1);
    send_point(-18'sd4096, 18'sd4096, 0);
    send_point(18'sd4096, -18'sd4096, 1);
    send_point(18'sd100, 18'sd0, 1);
    send_point(18'sd4096, 18'sd300, 0);
    send_point(18'sd2000, 18'sd250, 1);
    set_threshold(0);
    send_point(18'sd5, 18'sd0, 1);
    send_point(18'sd5, 18'sd1, 1);
    set_threshold(16'hFFFF);
    send_point(18'sd8000, 18'sd100, 0);
    send_point(18'sd8000, 18'sd181, 1);

    // Overfill the store so that points are dropped, the last one included.
    set_threshold(17);
    quiet_stretch = 1;
    for (int i = 0; i < MAXP + 3; i++)
      send_point(rand_coord(), rand_coord(), i == MAXP + 2);
    quiet_stretch = 0;

    while (point_total < 1350) begin
      case ($urandom_range(7))
        0: set_threshold(16'($urandom));
        1: set_threshold(16'hFFFF);
        2: set_threshold(0);
        default: ;
      endcase
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 8);
      quiet_stretch = ($urandom_range(9) == 0);
      send_batch(len);
    end
    quiet_stretch = 0;

    drain_fits();
    $display("Covered %0d points in %0d fits, %0d of them curved, over threshold extremes.",
             point_total, fit_sb.fits, fit_sb.curved);
    if (fit_sb.errors == 0)
      $display("[arc_radius_least_squares_fit_unit] OK");
    else
      $display("[arc_radius_least_squares_fit_unit] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
sv/arsf_pkg.sv
sv/arsf_point_ram.sv
sv/arsf_divider.sv
sv/arc_radius_least_squares_fit_unit.sv
dv/arc_radius_least_squares_fit_unit_test.sv
